/* rtl/gftu_pkg.sv */
// Shared types and constants of the GF(256) table arithmetic unit.
package gftu_pkg;

   // Operation codes carried in the func field of a request.
   localparam logic [2:0] FUNC_ADD = 3'd0;
   localparam logic [2:0] FUNC_MUL = 3'd1;
   localparam logic [2:0] FUNC_EXP = 3'd2;
   localparam logic [2:0] FUNC_LOG = 3'd3;
   localparam logic [2:0] FUNC_INV = 3'd4;

   // QR code polynomial, loaded at reset.
   localparam logic [8:0] POLY_RESET = 9'h11D;
   // Order of the multiplicative group.
   localparam logic [8:0] GROUP_ORDER = 9'd255;
   // Table depth; the build walk is finished when the index reaches it.
   localparam logic [8:0] TABLE_DEPTH = 9'h100;
   // The last exp entry takes no part in filling the log table.
   localparam logic [7:0] LOG_STOP = 8'd255;

   typedef struct packed {
      logic [7:0] log_a;
      logic [7:0] log_b;
   } log_pair_type;

   typedef struct packed {
      logic [7:0] value;
      logic       zero_error;
   } result_type;

endpackage

/* rtl/gftu_if.sv */
// Handshake channels of the GF(256) table arithmetic unit.
interface gftu_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] func;
   logic [7:0] operand_a;
   logic [7:0] operand_b;
   modport source (output valid, func, operand_a, operand_b, input ready);
   modport sink (input valid, func, operand_a, operand_b, output ready);
endinterface

interface gftu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] value;
   logic       zero_error;
   modport source (output valid, value, zero_error, input ready);
   modport sink (input valid, value, zero_error, output ready);
endinterface

interface gftu_csr_if;
   logic       valid;
   logic       ready;
   logic [8:0] field_polynomial;
   modport source (output valid, field_polynomial, input ready);
   modport sink (input valid, field_polynomial, output ready);
endinterface

/* rtl/gftu_tables.sv */
// Exponent and logarithm tables of GF(256) with their build walk.
module gftu_tables (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   poly_write,
   input  logic [8:0]             poly_data,
   output logic                   busy,
   input  logic [7:0]             log_addr_a,
   input  logic [7:0]             log_addr_b,
   output gftu_pkg::log_pair_type log_rd,
   input  logic [7:0]             exp_addr,
   output logic [7:0]             exp_rd
);

   // Bit 8 of the polynomial has no effect: the reduction is applied
   // whenever bit 7 shifts out, so only the low byte is kept.
   logic [7:0]   poly_ff;
   logic [8:0]   build_index_ff;
   logic [7:0]   x_ff;
   logic [7:0]   x_in;
   logic [255:0] log_valid_ff;
   logic         log_write;

   logic [7:0]   exp_mem [256];
   logic [7:0]   log_mem [256];

   logic [7:0]   log_a_ff;
   logic [7:0]   log_b_ff;
   logic         log_a_valid_ff;
   logic         log_b_valid_ff;
   logic [7:0]   exp_ff;

   assign busy = (build_index_ff != gftu_pkg::TABLE_DEPTH);
   assign x_in = {x_ff[6:0], 1'b0} ^ ({8{x_ff[7]}} & poly_ff);
   // Zero never receives a log entry, so it keeps reading as zero.
   assign log_write = busy && (build_index_ff[7:0] != gftu_pkg::LOG_STOP)
                      && (x_ff != 8'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff        <= gftu_pkg::POLY_RESET[7:0];
         build_index_ff <= 9'd0;
         x_ff           <= 8'd1;
         log_valid_ff   <= '0;
      end else if (poly_write) begin
         poly_ff        <= poly_data[7:0];
         build_index_ff <= 9'd0;
         x_ff           <= 8'd1;
         log_valid_ff   <= '0;
      end else if (busy) begin
         build_index_ff <= build_index_ff + 9'd1;
         x_ff           <= x_in;
         if (log_write) begin
            log_valid_ff[x_ff] <= 1'b1;
         end
      end
   end

   // Later walk steps overwrite earlier log entries for the same element.
   always_ff @(posedge clock) begin
      if (busy) begin
         exp_mem[build_index_ff[7:0]] <= x_ff;
      end
      if (log_write) begin
         log_mem[x_ff] <= build_index_ff[7:0];
      end
      log_a_ff       <= log_mem[log_addr_a];
      log_b_ff       <= log_mem[log_addr_b];
      log_a_valid_ff <= log_valid_ff[log_addr_a];
      log_b_valid_ff <= log_valid_ff[log_addr_b];
      exp_ff         <= exp_mem[exp_addr];
   end

   assign log_rd.log_a = log_a_valid_ff ? log_a_ff : 8'd0;
   assign log_rd.log_b = log_b_valid_ff ? log_b_ff : 8'd0;
   assign exp_rd       = exp_ff;

endmodule

/* rtl/gf256_table_arithmetic_unit_top.sv */
// Top level of the GF(256) table arithmetic unit.
//
//   channel  direction  transaction carries
//   req_ch   in         func, operand_a, operand_b
//   rsp_ch   out        value, zero_error
//   csr_ch   in         field_polynomial (rebuilds the tables)
//
// One transaction per cycle is accepted while req_ch is ready; each result
// passes through the registered log read, the registered exp read and the
// result queue. After reset or a polynomial write the tables are rebuilt in
// a walk over the 256 indices, one exp entry per cycle, holding off req_ch.
// A stalled rsp_ch fills a four-entry result queue; requests are taken
// while fewer than four results are outstanding.
module gf256_table_arithmetic_unit_top (
   input logic      clock,
   input logic      reset,
   gftu_req_if.sink req_ch,
   gftu_rsp_if.source rsp_ch,
   gftu_csr_if.sink csr_ch
);

   localparam int RESULT_DEPTH = 4;
   localparam int PTR_WIDTH    = $clog2(RESULT_DEPTH);
   localparam int CNT_WIDTH    = $clog2(RESULT_DEPTH + 1);

   logic                   busy;
   logic                   accept;
   logic                   pop;
   gftu_pkg::log_pair_type log_rd;
   logic [7:0]             exp_addr;
   logic [7:0]             exp_rd;

   // First stage: operands wait for the log reads.
   logic       s1_valid_ff;
   logic [2:0] s1_func_ff;
   logic [7:0] s1_a_ff;
   logic [7:0] s1_b_ff;

   // Second stage: direct result or pending exp read.
   logic       s2_valid_ff;
   logic [7:0] s2_direct_ff;
   logic       s2_use_exp_ff;
   logic       s2_err_ff;
   logic [7:0] s2_direct_in;
   logic       s2_use_exp_in;
   logic       s2_err_in;

   logic [8:0] log_sum;
   logic [8:0] log_sum_mod;
   logic [8:0] inv_exp;

   gftu_pkg::result_type   queue_ff [RESULT_DEPTH];
   gftu_pkg::result_type   push_data;
   logic [PTR_WIDTH-1:0]   wr_ptr_ff;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff;
   logic [CNT_WIDTH-1:0]   count_ff;
   logic [CNT_WIDTH-1:0]   count_in;
   logic [CNT_WIDTH-1:0]   pending_ff;
   logic [CNT_WIDTH-1:0]   pending_in;

   gftu_tables u_tables (
      .clock      (clock),
      .reset      (reset),
      .poly_write (csr_ch.valid),
      .poly_data  (csr_ch.field_polynomial),
      .busy       (busy),
      .log_addr_a (req_ch.operand_a),
      .log_addr_b (req_ch.operand_b),
      .log_rd     (log_rd),
      .exp_addr   (exp_addr),
      .exp_rd     (exp_rd)
   );

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = !busy && (pending_ff != CNT_WIDTH'(RESULT_DEPTH));
   assign accept       = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_func_ff    <= req_ch.func;
      s1_a_ff       <= req_ch.operand_a;
      s1_b_ff       <= req_ch.operand_b;
      s2_direct_ff  <= s2_direct_in;
      s2_use_exp_ff <= s2_use_exp_in;
      s2_err_ff     <= s2_err_in;
   end

   // The sum of two logs stays below twice the group order.
   assign log_sum     = {1'b0, log_rd.log_a} + {1'b0, log_rd.log_b};
   assign log_sum_mod = (log_sum >= gftu_pkg::GROUP_ORDER) ?
                        (log_sum - gftu_pkg::GROUP_ORDER) : log_sum;
   assign inv_exp     = gftu_pkg::GROUP_ORDER - {1'b0, log_rd.log_a};

   always_comb begin
      exp_addr      = s1_a_ff;
      s2_direct_in  = 8'd0;
      s2_use_exp_in = 1'b0;
      s2_err_in     = 1'b0;
      unique case (s1_func_ff)
         gftu_pkg::FUNC_ADD: begin
            s2_direct_in = s1_a_ff ^ s1_b_ff;
         end
         gftu_pkg::FUNC_MUL: begin
            exp_addr = log_sum_mod[7:0];
            priority if ((s1_a_ff == 8'd0) || (s1_b_ff == 8'd0)) begin
               s2_direct_in = 8'd0;
            end else if (s1_a_ff == 8'd1) begin
               s2_direct_in = s1_b_ff;
            end else if (s1_b_ff == 8'd1) begin
               s2_direct_in = s1_a_ff;
            end else begin
               s2_use_exp_in = 1'b1;
            end
         end
         gftu_pkg::FUNC_EXP: begin
            s2_use_exp_in = 1'b1;
         end
         gftu_pkg::FUNC_LOG: begin
            if (s1_a_ff == 8'd0) begin
               s2_err_in = 1'b1;
            end else begin
               s2_direct_in = log_rd.log_a;
            end
         end
         gftu_pkg::FUNC_INV: begin
            exp_addr = inv_exp[7:0];
            if (s1_a_ff == 8'd0) begin
               s2_err_in = 1'b1;
            end else begin
               s2_use_exp_in = 1'b1;
            end
         end
         default: begin
            s2_direct_in = 8'd0;
         end
      endcase
   end

   assign push_data.value      = s2_use_exp_ff ? exp_rd : s2_direct_ff;
   assign push_data.zero_error = s2_err_ff;

   // Result queue: it never overflows, as requests are limited by the
   // number of outstanding results.
   assign pop        = rsp_ch.valid && rsp_ch.ready;
   assign count_in   = count_ff + CNT_WIDTH'(s2_valid_ff) - CNT_WIDTH'(pop);
   assign pending_in = pending_ff + CNT_WIDTH'(accept) - CNT_WIDTH'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         count_ff   <= '0;
         pending_ff <= '0;
      end else begin
         count_ff   <= count_in;
         pending_ff <= pending_in;
         if (s2_valid_ff) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_WIDTH'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         queue_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign rsp_ch.valid      = (count_ff != '0);
   assign rsp_ch.value      = queue_ff[rd_ptr_ff].value;
   assign rsp_ch.zero_error = queue_ff[rd_ptr_ff].zero_error;

endmodule
